[rtl/u8lc_pkg.sv]
// ----------------------------------------------------------------------------
// u8lc_pkg
// Shared types, constants and helpers for the UTF-8 line/column indexer.
// ----------------------------------------------------------------------------
`default_nettype none

package u8lc_pkg;

   localparam int unsigned POS_W = 32;
   localparam int unsigned CP_W  = 21;

   // Byte that starts a new line.
   localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

   // Announced sequence lengths.
   localparam logic [2:0] SEQ_LEN_NONE = 3'd0;
   localparam logic [2:0] SEQ_LEN_2    = 3'd2;
   localparam logic [2:0] SEQ_LEN_3    = 3'd3;
   localparam logic [2:0] SEQ_LEN_4    = 3'd4;

   // First code point that needs a surrogate pair.
   localparam logic [CP_W-1:0] SUPPLEMENTARY_BASE = 21'h10000;

   // One step's list of positions, as handed to the result emitter.
   typedef struct packed {
      logic [POS_W-1:0] line;      // line of the first non-end result
      logic [POS_W-1:0] col;       // column of the first non-end result
      logic [2:0]       count;     // number of non-end results (0..4)
      logic             seq;       // 1: columns step by one, 0: all equal
      logic             has_end;   // an end position follows
      logic [POS_W-1:0] end_line;
      logic [POS_W-1:0] end_col;
   } u8lc_desc_type;

   // Saturating add of a small count to a position counter.
   function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] x,
                                                input logic [2:0] u);
      logic [POS_W:0] s;
      s = {1'b0, x} + {{(POS_W-2){1'b0}}, u};
      return s[POS_W] ? {POS_W{1'b1}} : s[POS_W-1:0];
   endfunction

endpackage

`default_nettype wire

[rtl/u8lc_emit.sv]
// ----------------------------------------------------------------------------
// u8lc_emit
// Result register that plays out a step's positions, one beat per ready cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module u8lc_emit
   import u8lc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          load,
   input  wire u8lc_desc_type desc,
   output logic               free,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [63:0]        rsp_tdata,   // [31:0] line_number, [63:32] utf16_column
   output logic               rsp_tlast,   // last_of_run
   output logic [0:0]         rsp_tuser    // [0] is_end_position
);

   logic             valid_ff,    valid_in;
   logic [POS_W-1:0] line_ff,     line_in;
   logic [POS_W-1:0] col_ff,      col_in;
   logic             is_end_ff,   is_end_in;
   logic             last_ff,     last_in;
   logic [1:0]       remain_ff,   remain_in;
   logic             seq_ff,      seq_in;
   logic             pend_ff,     pend_in;
   logic [POS_W-1:0] end_line_ff, end_line_in;
   logic [POS_W-1:0] end_col_ff,  end_col_in;
   logic             pop;

   assign pop  = valid_ff && rsp_tready;
   // The register can take a new list once its last beat leaves.
   assign free = !valid_ff || (rsp_tready && remain_ff == 2'd0 && !pend_ff);

   // Next beat: a fresh list, the next position of the current list, or idle.
   always_comb begin
      valid_in    = valid_ff;
      line_in     = line_ff;
      col_in      = col_ff;
      is_end_in   = is_end_ff;
      last_in     = last_ff;
      remain_in   = remain_ff;
      seq_in      = seq_ff;
      pend_in     = pend_ff;
      end_line_in = end_line_ff;
      end_col_in  = end_col_ff;
      if (load) begin
         seq_in      = desc.seq;
         end_line_in = desc.end_line;
         end_col_in  = desc.end_col;
         if (desc.count != 3'd0) begin
            valid_in  = 1'b1;
            line_in   = desc.line;
            col_in    = desc.col;
            is_end_in = 1'b0;
            remain_in = 2'(desc.count - 3'd1);
            last_in   = (desc.count == 3'd1) && !desc.has_end;
            pend_in   = desc.has_end;
         end else if (desc.has_end) begin
            valid_in  = 1'b1;
            line_in   = desc.end_line;
            col_in    = desc.end_col;
            is_end_in = 1'b1;
            remain_in = 2'd0;
            last_in   = 1'b1;
            pend_in   = 1'b0;
         end else begin
            valid_in  = 1'b0;
            remain_in = 2'd0;
            pend_in   = 1'b0;
         end
      end else if (pop) begin
         if (remain_ff != 2'd0) begin
            col_in    = seq_ff ? sat_add(col_ff, 3'd1) : col_ff;
            remain_in = remain_ff - 2'd1;
            last_in   = (remain_ff == 2'd1) && !pend_ff;
         end else if (pend_ff) begin
            line_in   = end_line_ff;
            col_in    = end_col_ff;
            is_end_in = 1'b1;
            last_in   = 1'b1;
            pend_in   = 1'b0;
         end else begin
            valid_in  = 1'b0;
         end
      end
   end

   // Control state is cleared; position payload needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         remain_ff <= 2'd0;
         pend_ff   <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         remain_ff <= remain_in;
         pend_ff   <= pend_in;
      end
      line_ff     <= line_in;
      col_ff      <= col_in;
      is_end_ff   <= is_end_in;
      last_ff     <= last_in;
      seq_ff      <= seq_in;
      end_line_ff <= end_line_in;
      end_col_ff  <= end_col_in;
   end

   assign rsp_tvalid   = valid_ff;
   assign rsp_tdata    = {col_ff, line_ff};
   assign rsp_tlast    = last_ff;
   assign rsp_tuser[0] = is_end_ff;

endmodule

`default_nettype wire

[rtl/utf8_line_column_indexer.sv]
// ----------------------------------------------------------------------------
// utf8_line_column_indexer
// Reports the line and UTF-16 column of every UTF-8 byte, plus the end position.
// ----------------------------------------------------------------------------
// The first result beat of a byte passes the input register, then the result
// register. Throughput: one byte per cycle while each byte gives at most one
// result and the receiver is ready; a byte that gives several results holds
// the input side until the result register has played them all out.
// Synchronous active-high reset clears line, column and any pending
// sequence; no clearing pass is needed.
`default_nettype none

module utf8_line_column_indexer
   import u8lc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] byte_value
   input  wire logic        req_tlast,   // end_of_text
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // [31:0] line_number, [63:32] utf16_column
   output logic             rsp_tlast,   // last_of_run
   output logic [0:0]       rsp_tuser    // [0] is_end_position
);

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             in_eot_ff;
   logic [1:0]       held_ff,  held_in;
   logic [2:0]       exp_ff,   exp_in;
   logic [CP_W-1:0]  cp_ff,    cp_in;
   logic [POS_W-1:0] line_ff,  line_in;
   logic [POS_W-1:0] col_ff,   col_in;
   logic             emit_free;
   logic             proc;
   logic             take;
   u8lc_desc_type    desc;

   assign proc       = in_valid_ff && emit_free;
   assign req_tready = !in_valid_ff || proc;
   assign take       = req_tvalid && req_tready;

   // Input register.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (take)
         in_valid_in = 1'b1;
      else if (proc)
         in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (take) begin
         in_byte_ff <= req_tdata;
         in_eot_ff  <= req_tlast;
      end
   end

   // One decoding step: builds the result list and the next counter state.
   always_comb begin
      logic [CP_W-1:0] cp_next;
      logic [2:0]      n;
      logic [2:0]      units;
      logic            is_cont;

      held_in  = held_ff;
      exp_in   = exp_ff;
      cp_in    = cp_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      n        = 3'd0;
      units    = 3'd1;
      is_cont  = (in_byte_ff[7:6] == 2'b10);
      cp_next  = {cp_ff[CP_W-7:0], in_byte_ff[5:0]};
      desc.seq = 1'b1;

      if (held_ff != 2'd0 && is_cont) begin
         if ({1'b0, held_ff} + 3'd1 >= exp_ff) begin
            // Sequence complete: every byte reports the same position.
            n        = exp_ff;
            desc.seq = 1'b0;
            if (exp_ff == SEQ_LEN_4 && cp_next >= SUPPLEMENTARY_BASE)
               units = 3'd2;
            col_in  = sat_add(col_ff, units);
            held_in = 2'd0;
            exp_in  = SEQ_LEN_NONE;
            cp_in   = '0;
         end else begin
            held_in = held_ff + 2'd1;
            cp_in   = cp_next;
         end
      end else begin
         // A broken sequence reports each held byte as one unit.
         if (held_ff != 2'd0) begin
            n       = {1'b0, held_ff};
            col_in  = sat_add(col_ff, {1'b0, held_ff});
            held_in = 2'd0;
            exp_in  = SEQ_LEN_NONE;
            cp_in   = '0;
         end
         // The byte examined on its own.
         if (!in_byte_ff[7]) begin
            n = n + 3'd1;
            if (in_byte_ff == NEWLINE_BYTE) begin
               line_in = (line_in == {POS_W{1'b1}}) ? line_in : line_in + 1'b1;
               col_in  = '0;
            end else begin
               col_in  = sat_add(col_in, 3'd1);
            end
         end else if (in_byte_ff[7:5] == 3'b110) begin
            held_in = 2'd1;
            exp_in  = SEQ_LEN_2;
            cp_in   = CP_W'(in_byte_ff[4:0]);
         end else if (in_byte_ff[7:4] == 4'b1110) begin
            held_in = 2'd1;
            exp_in  = SEQ_LEN_3;
            cp_in   = CP_W'(in_byte_ff[3:0]);
         end else if (in_byte_ff[7:3] == 5'b11110) begin
            held_in = 2'd1;
            exp_in  = SEQ_LEN_4;
            cp_in   = CP_W'(in_byte_ff[2:0]);
         end else begin
            n      = n + 3'd1;
            col_in = sat_add(col_in, 3'd1);
         end
      end

      // End of text: flush what is still held, report the end, start over.
      desc.end_line = line_in;
      desc.end_col  = col_in;
      if (in_eot_ff) begin
         n             = n + {1'b0, held_in};
         desc.end_col  = sat_add(col_in, {1'b0, held_in});
         held_in       = 2'd0;
         exp_in        = SEQ_LEN_NONE;
         cp_in         = '0;
         line_in       = '0;
         col_in        = '0;
      end

      desc.line    = line_ff;
      desc.col     = col_ff;
      desc.count   = n;
      desc.has_end = in_eot_ff;
   end

   // Decoder state.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 2'd0;
         exp_ff  <= SEQ_LEN_NONE;
         cp_ff   <= '0;
         line_ff <= '0;
         col_ff  <= '0;
      end else if (proc) begin
         held_ff <= held_in;
         exp_ff  <= exp_in;
         cp_ff   <= cp_in;
         line_ff <= line_in;
         col_ff  <= col_in;
      end
   end

   // Result register and beat sequencer.
   u8lc_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (proc),
      .desc       (desc),
      .free       (emit_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for utf8_line_column_indexer
// Streams UTF-8 text into the indexer. The text is a directed table followed by
// random well-formed and broken sequences. Each accepted byte is run through a
// local line/column tracker. Every result beat is compared with the oldest
// position still due.
// ----------------------------------------------------------------------------
module tb
   import u8lc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_BEATS     = 5;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_BYTES  = 93;
   localparam int REPORT_LIMIT  = 10;
   localparam int IDLE_PERCENT  = 22;

   // One position beat as the indexer reports it.
   typedef struct packed {
      logic [POS_W-1:0] line;
      logic [POS_W-1:0] col;
      logic             is_end;
      logic             last;
   } text_pos_type;

   // One byte of text. A pinned row also carries the position that its first
   // result must show.
   typedef struct packed {
      logic [7:0]       val;
      logic             eot;
      logic             pinned;
      logic [POS_W-1:0] pin_line;
      logic [POS_W-1:0] pin_col;
   } text_row_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [7:0]       req_tdata;    // [7:0] byte_value
   logic             req_tlast;    // end_of_text
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [63:0]      rsp_tdata;    // [31:0] line_number, [63:32] utf16_column
   logic             rsp_tlast;    // last_of_run
   logic [0:0]       rsp_tuser;    // [0] is_end_position

   utf8_line_column_indexer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // Directed text: ASCII extremes, newline, every sequence length, strays,
   // an overlong form, broken sequences, truncation at the end, and a text
   // that starts right after an end.
   text_row_type directed_rows [27] = '{
      '{8'h00, 1'b0, 1'b1, 32'd0, 32'd0},
      '{8'h7F, 1'b0, 1'b1, 32'd0, 32'd1},
      '{8'h0A, 1'b0, 1'b1, 32'd0, 32'd2},
      '{8'hC3, 1'b0, 1'b0, 32'd0, 32'd0},
      '{8'hA9, 1'b0, 1'b1, 32'd1, 32'd0},
      '{8'hE2, 1'b0, 1'b0, 32'd0, 32'd0},
      '{8'h82, 1'b0, 1'b0, 32'd0, 32'd0},
      '{8'hAC, 1'b0, 1'b1, 32'd1, 32'd1},
      '{8'hF0, 1'b0, 1'b0, 32'd0, 32'd0},
      '{8'h9F, 1'b0, 1'b0, 32'd0, 32'd0},
      '{8'h98, 1'b0, 1'b0, 32'd0, 32'd0},
      '{8'h80, 1'b0, 1'b1, 32'd1, 32'd2},
      '{8'h80, 1'b0, 1'b1, 32'd1, 32'd4},
      '{8'hFF, 1'b0, 1'b1, 32'd1, 32'd5},
      '{8'hF8, 1'b0, 1'b1, 32'd1, 32'd6},
      '{8'hF0, 1'b0, 1'b0, 32'd0, 32'd0},
      '{8'h80, 1'b0, 1'b0, 32'd0, 32'd0},
      '{8'h80, 1'b0, 1'b0, 32'd0, 32'd0},
      '{8'h80, 1'b0, 1'b1, 32'd1, 32'd7},
      '{8'hE0, 1'b0, 1'b0, 32'd0, 32'd0},
      '{8'h41, 1'b0, 1'b1, 32'd1, 32'd8},
      '{8'hF4, 1'b0, 1'b0, 32'd0, 32'd0},
      '{8'h8F, 1'b0, 1'b0, 32'd0, 32'd0},
      '{8'h0A, 1'b0, 1'b1, 32'd1, 32'd10},
      '{8'hDF, 1'b0, 1'b0, 32'd0, 32'd0},
      '{8'hC2, 1'b1, 1'b1, 32'd2, 32'd0},
      '{8'h20, 1'b1, 1'b1, 32'd0, 32'd0}
   };

   text_row_type  text_rows [$];
   text_pos_type  due_positions [$];
   text_pos_type  step_positions [$];
   text_row_type  live_row;
   int            row_pos;
   int            mismatches;
   int            cycle_count;

   // Tracker state: the pending multi-byte sequence and the current position.
   logic [1:0]       seq_held;
   logic [2:0]       seq_len;
   logic [CP_W-1:0]  seq_code;
   logic [POS_W-1:0] at_line;
   logic [POS_W-1:0] at_col;

   // Clock with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Line/column tracker
   // ------------------------------------------------------------------
   task automatic clear_tracker();
      seq_held = '0;
      seq_len  = SEQ_LEN_NONE;
      seq_code = '0;
      at_line  = '0;
      at_col   = '0;
   endtask

   task automatic report_here(input logic is_end);
      text_pos_type p;
      if (step_positions.size() < MAX_BEATS) begin
         p.line   = at_line;
         p.col    = at_col;
         p.is_end = is_end;
         p.last   = 1'b0;
         step_positions = {step_positions, p};
      end
   endtask

   // The column saturates instead of wrapping.
   task automatic step_column(input logic [1:0] units);
      if (at_col > {POS_W{1'b1}} - units)
         at_col = {POS_W{1'b1}};
      else
         at_col = at_col + units;
   endtask

   // Every held byte of a broken sequence counts as one unit of its own.
   task automatic release_held();
      for (int k = 0; k < seq_held; k++) begin
         report_here(1'b0);
         step_column(2'd1);
      end
      seq_held = '0;
      seq_len  = SEQ_LEN_NONE;
      seq_code = '0;
   endtask

   task automatic start_sequence(input logic [2:0] len, input logic [CP_W-1:0] bits);
      seq_held = 2'd1;
      seq_len  = len;
      seq_code = bits;
   endtask

   task automatic take_fresh(input logic [7:0] b);
      if (b[7] == 1'b0) begin
         report_here(1'b0);
         if (b == NEWLINE_BYTE) begin
            if (at_line != {POS_W{1'b1}})
               at_line = at_line + 1'b1;
            at_col = '0;
         end else begin
            step_column(2'd1);
         end
      end else if ((b & 8'hE0) == 8'hC0) begin
         start_sequence(SEQ_LEN_2, CP_W'(b & 8'h1F));
      end else if ((b & 8'hF0) == 8'hE0) begin
         start_sequence(SEQ_LEN_3, CP_W'(b & 8'h0F));
      end else if ((b & 8'hF8) == 8'hF0) begin
         start_sequence(SEQ_LEN_4, CP_W'(b & 8'h07));
      end else begin
         report_here(1'b0);
         step_column(2'd1);
      end
   endtask

   // Works out the positions one accepted byte gives, into step_positions.
   task automatic index_byte(input logic [7:0] b, input logic eot);
      step_positions.delete();
      if (seq_held == 0) begin
         take_fresh(b);
      end else if ((b & 8'hC0) == 8'h80) begin
         seq_code = {seq_code[CP_W-7:0], b[5:0]};
         if (int'(seq_held) + 1 >= int'(seq_len)) begin
            for (int k = 0; k < seq_len; k++)
               report_here(1'b0);
            step_column((seq_len == SEQ_LEN_4 && seq_code >= SUPPLEMENTARY_BASE) ? 2'd2
                                                                                 : 2'd1);
            seq_held = '0;
            seq_len  = SEQ_LEN_NONE;
            seq_code = '0;
         end else begin
            seq_held = seq_held + 1'b1;
         end
      end else begin
         release_held();
         take_fresh(b);
      end

      // A text that ends with a sequence still open reports it as broken.
      if (eot) begin
         release_held();
         report_here(1'b1);
         clear_tracker();
      end

      if (step_positions.size() > 0)
         step_positions[step_positions.size()-1].last = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Random text
   // ------------------------------------------------------------------
   task automatic add_byte(input logic [7:0] v);
      text_row_type r;
      r = '0;
      r.val = v;
      r.eot = ($urandom_range(0, 39) == 0);
      text_rows = {text_rows, r};
   endtask

   function automatic logic [7:0] any_continuation();
      return 8'h80 | 8'($urandom_range(0, 63));
   endfunction

   // Mostly well-formed code points, with broken and stray bytes mixed in.
   task automatic add_token();
      int pick;
      int len;
      logic [7:0] lead;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         add_byte(($urandom_range(0, 3) == 0) ? NEWLINE_BYTE : 8'($urandom_range(0, 127)));
      end else if (pick < 85) begin
         if (pick < 45) begin
            len = 2;
         end else if (pick < 60) begin
            len = 3;
         end else if (pick < 75) begin
            len = 4;
         end else begin
            len = $urandom_range(2, 4);
         end
         case (len)
            2: lead = 8'hC0 | 8'($urandom_range(0, 31));
            3: lead = 8'hE0 | 8'($urandom_range(0, 15));
            default: lead = 8'hF0 | 8'($urandom_range(0, 7));
         endcase
         add_byte(lead);
         // A truncated sequence stops short of its full length.
         if (pick >= 75)
            len = $urandom_range(1, len - 1);
         for (int k = 1; k < len; k++)
            add_byte(any_continuation());
      end else if (pick < 93) begin
         add_byte(($urandom_range(0, 1) == 0) ? any_continuation()
                                              : 8'hF8 | 8'($urandom_range(0, 7)));
      end else begin
         add_byte(8'($urandom_range(0, 255)));
      end
   endtask

   // ------------------------------------------------------------------
   // Mismatch reporting
   // ------------------------------------------------------------------
   task automatic log_mismatch(input logic orphan, input text_pos_type want,
                               input text_pos_type got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         if (orphan) begin
            $display("%0t: result beat with nothing due: line %0d col %0d end %0b last %0b",
                     $time, got.line, got.col, got.is_end, got.last);
         end else begin
            $write("%0t: expected line %0d col %0d end %0b last %0b, ",
                   $time, want.line, want.col, want.is_end, want.last);
            $display("got line %0d col %0d end %0b last %0b",
                     got.line, got.col, got.is_end, got.last);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Byte driver
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         // Random gaps, except over a stretch in the middle of the text.
         if (row_pos < text_rows.size() &&
             !((row_pos < 40 || row_pos >= 90) && $urandom_range(0, 99) < IDLE_PERCENT)) begin
            live_row   <= text_rows[row_pos];
            req_tdata  <= text_rows[row_pos].val;
            req_tlast  <= text_rows[row_pos].eot;
            req_tvalid <= 1'b1;
            row_pos    <= row_pos + 1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver with random stalls and a stretch without any.
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= (row_pos >= 50 && row_pos < 100) ||
                       ($urandom_range(0, 99) >= IDLE_PERCENT);
   end

   // ------------------------------------------------------------------
   // Prediction and checking
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      text_pos_type got;
      text_pos_type want;
      if (reset) begin
         clear_tracker();
      end else begin
         // An accepted byte adds its positions to the ones still due.
         if (req_tvalid && req_tready) begin
            index_byte(req_tdata, req_tlast);
            if (live_row.pinned && step_positions.size() > 0) begin
               step_positions[0].line = live_row.pin_line;
               step_positions[0].col  = live_row.pin_col;
            end
            due_positions = {due_positions, step_positions};
         end

         // Each result beat must match the oldest position due.
         if (rsp_tvalid && rsp_tready) begin
            got.line   = rsp_tdata[31:0];
            got.col    = rsp_tdata[63:32];
            got.is_end = rsp_tuser[0];
            got.last   = rsp_tlast;
            if (due_positions.size() == 0) begin
               log_mismatch(1'b1, got, got);
            end else begin
               want = due_positions.pop_front();
               if (got.line !== want.line || got.col !== want.col ||
                   got.is_end !== want.is_end || got.last !== want.last)
                  log_mismatch(1'b0, want, got);
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL utf8_line_column_indexer");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      rsp_tready  = 1'b0;
      live_row    = '0;
      row_pos     = 0;
      mismatches  = 0;
      cycle_count = 0;

      foreach (directed_rows[i])
         text_rows = {text_rows, directed_rows[i]};
      while (text_rows.size() < $size(directed_rows) + RANDOM_BYTES)
         add_token();
      // Close the last text so any open sequence gets flushed.
      text_rows[text_rows.size()-1].eot = 1'b1;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Wait for every byte to be taken and every position to come back.
      @(posedge clock);
      while (row_pos < text_rows.size() || req_tvalid || due_positions.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatches == 0)
         $display("PASS utf8_line_column_indexer");
      else
         $display("FAIL utf8_line_column_indexer");
      $finish;
   end

endmodule
